/* hdl/pdcd_pkg.sv */
// ----------------------------------------------------------------------------
// pdcd_pkg
// shared widths, calendar constants and the month length table of the
// packed day count to date unit
// ----------------------------------------------------------------------------
package pdcd_pkg;

    localparam int STAMP_W   = 25;
    localparam int DAY_W     = 14;
    localparam int MIN_W     = 11;
    localparam int YEAR_W    = 11;
    localparam int MONTH_W   = 4;
    localparam int DAYOM_W   = 5;
    localparam int HOUR_W    = 6;
    localparam int MINUTE_W  = 6;
    localparam int YOFF_W    = 6;
    localparam int LEN_W     = 9;

    localparam int BASE_YEAR      = 1964;
    localparam int LAST_GOOD_YEAR = 1999;
    localparam int LAST_GOOD_OFF  = LAST_GOOD_YEAR - BASE_YEAR;

    localparam int MIN_PER_HOUR   = 60;
    // hour = (minutes * HOUR_RECIP) >> HOUR_SHIFT, exact for 11-bit minutes
    localparam int HOUR_RECIP     = 2185;
    localparam int HOUR_SHIFT     = 17;
    localparam int RECIP_W        = 12;
    localparam int PROD_W         = MIN_W + RECIP_W;

    localparam logic [LEN_W-1:0] LEN_LEAP_YEAR = LEN_W'(366);
    localparam logic [LEN_W-1:0] LEN_YEAR      = LEN_W'(365);

    typedef logic [MONTH_W-1:0] t_month;
    typedef logic [LEN_W-1:0]   t_len;

    localparam t_month MON_FEB = MONTH_W'(1);
    localparam t_month MON_APR = MONTH_W'(3);
    localparam t_month MON_JUN = MONTH_W'(5);
    localparam t_month MON_SEP = MONTH_W'(8);
    localparam t_month MON_NOV = MONTH_W'(10);

    // month index 0 is january
    function automatic t_len month_len(input t_month mon, input logic leap);
        t_len len;
        if (mon == MON_FEB) begin
            len = leap ? LEN_W'(29) : LEN_W'(28);
        end else if (mon inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}) begin
            len = LEN_W'(30);
        end else begin
            len = LEN_W'(31);
        end
        return len;
    endfunction

endpackage

/* hdl/packed_day_count_to_date_unit.sv */
// ----------------------------------------------------------------------------
// packed_day_count_to_date_unit
// splits a packed stamp word into calendar date and clock time
//
//   channel | signals                                   | direction
//   input   | i_valid, o_ready, i_stamp_word            | request in
//   output  | o_valid, i_ready, o_cal_year .. o_year_.. | result out
//
// after accept the sequencer removes Y whole years and then M whole months
// from the day count, where Y (0..44) is the number of whole years and M
// (0..11) the number of whole months in it, one year or one month per cycle
// through the single shared subtract and compare unit, then holds the result.
// o_ready is high only while idle; a held result stalls the unit until taken.
// synchronous active-low reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module packed_day_count_to_date_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pdcd_pkg::STAMP_W-1:0] i_stamp_word,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pdcd_pkg::YEAR_W-1:0]  o_cal_year,
    output logic [pdcd_pkg::MONTH_W-1:0] o_cal_month,
    output logic [pdcd_pkg::DAYOM_W-1:0] o_cal_day,
    output logic [pdcd_pkg::HOUR_W-1:0]  o_clock_hour,
    output logic [pdcd_pkg::MINUTE_W-1:0] o_clock_minute,
    output logic                         o_year_out_of_range
);
    import pdcd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_YEAR  = 2'd1;
    localparam logic [1:0] ST_MONTH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [DAY_W-1:0]  r_left,  n_left;
    logic [YOFF_W-1:0] r_yoff,  n_yoff;
    t_month            r_mon,   n_mon;
    logic [MIN_W-1:0]  r_mins,  n_mins;
    logic [HOUR_W-1:0] r_hour,  n_hour;

    logic [MIN_W-1:0]  w_min_field;
    logic [PROD_W-1:0] w_prod;
    logic              w_leap;
    t_len              w_len;
    logic [DAY_W:0]    w_diff;
    logic              w_borrow;
    logic [MIN_W-1:0]  w_minute;

    assign w_min_field = i_stamp_word[DAY_W +: MIN_W];
    assign w_prod      = PROD_W'(w_min_field) * PROD_W'(HOUR_RECIP);
    assign w_leap      = (r_yoff[1:0] == 2'd0);

    // shared subtract and compare unit
    always_comb begin
        if (r_state == ST_YEAR) begin
            w_len = w_leap ? LEN_LEAP_YEAR : LEN_YEAR;
        end else begin
            w_len = month_len(r_mon, w_leap);
        end
    end
    assign w_diff   = {1'b0, r_left} - (DAY_W + 1)'(w_len);
    assign w_borrow = w_diff[DAY_W];

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_yoff  = r_yoff;
        n_mon   = r_mon;
        n_mins  = r_mins;
        n_hour  = r_hour;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_left  = i_stamp_word[DAY_W-1:0];
                    n_mins  = w_min_field;
                    n_hour  = w_prod[HOUR_SHIFT +: HOUR_W];
                    n_yoff  = '0;
                    n_mon   = '0;
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (w_borrow) begin
                    n_state = ST_MONTH;
                end else begin
                    n_left = w_diff[DAY_W-1:0];
                    n_yoff = r_yoff + YOFF_W'(1);
                end
            end
            ST_MONTH: begin
                if (w_borrow) begin
                    n_state = ST_DONE;
                end else begin
                    n_left = w_diff[DAY_W-1:0];
                    n_mon  = r_mon + MONTH_W'(1);
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_left <= n_left;
        r_yoff <= n_yoff;
        r_mon  <= n_mon;
        r_mins <= n_mins;
        r_hour <= n_hour;
    end

    assign w_minute = r_mins - (MIN_W'(r_hour) * MIN_W'(MIN_PER_HOUR));

    assign o_ready             = (r_state == ST_IDLE);
    assign o_valid             = (r_state == ST_DONE);
    assign o_cal_year          = YEAR_W'(BASE_YEAR) + YEAR_W'(r_yoff);
    assign o_cal_month         = r_mon + MONTH_W'(1);
    assign o_cal_day           = r_left[DAYOM_W-1:0] + DAYOM_W'(1);
    assign o_clock_hour        = r_hour;
    assign o_clock_minute      = w_minute[MINUTE_W-1:0];
    assign o_year_out_of_range = (r_yoff > YOFF_W'(LAST_GOOD_OFF));

endmodule

/* hdl/pdcd_checker.sv */
// ----------------------------------------------------------------------------
// pdcd_checker
// port-level checks of the packed day count to date unit, bound to the top
// ----------------------------------------------------------------------------
module pdcd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [pdcd_pkg::STAMP_W-1:0]  i_stamp_word,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [pdcd_pkg::YEAR_W-1:0]   o_cal_year,
    input logic [pdcd_pkg::MONTH_W-1:0]  o_cal_month,
    input logic [pdcd_pkg::DAYOM_W-1:0]  o_cal_day,
    input logic [pdcd_pkg::HOUR_W-1:0]   o_clock_hour,
    input logic [pdcd_pkg::MINUTE_W-1:0] o_clock_minute,
    input logic                          o_year_out_of_range
);
    import pdcd_pkg::*;

    // a held result keeps its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cal_year) && $stable(o_cal_month)
            && $stable(o_cal_day) && $stable(o_clock_hour) && $stable(o_clock_minute))
        else $error("held result changed");

    // one request in flight at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready after accept");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while result pending");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cal_month >= MONTH_W'(1)) && (o_cal_month <= MONTH_W'(12))
            && (o_cal_day != '0) && (o_clock_minute < MINUTE_W'(MIN_PER_HOUR)))
        else $error("date or time field out of range");

    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_out_of_range == (o_cal_year > YEAR_W'(LAST_GOOD_YEAR))))
        else $error("year range flag mismatch");

endmodule

bind packed_day_count_to_date_unit pdcd_checker u_pdcd_checker (.*);
